// File: rtl/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg - shared types and constants for the barometric compensation block
// Holds calibration constants, register indexes and the divider sideband type.
// ----------------------------------------------------------------------------
`default_nettype none

package btc_pkg;

  // calibration constants of the integer compensation
  localparam int unsigned FineOffset = 128000;
  localparam int unsigned PressBase  = 1048576;
  localparam int unsigned PressScale = 3125;
  localparam int unsigned RoundHalf  = 128;

  // width of the divider datapath
  localparam int unsigned DivBits = 64;

  // configuration register indexes
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] CFG_TEMP_COEF  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_PRESS_NINE = 3'd3;

  // per-request fields that ride along the divider
  typedef struct packed {
    logic [31:0] fine;
    logic [23:0] tcent;
    logic        fault;
  } side_t;

endpackage

`default_nettype wire

// File: rtl/baro_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_compensation - integer temperature and pressure compensation
// Pipeline: 80 register stages from the accepting edge to out_valid:
// 10 front stages, a 66-stage bit-per-stage divider, 4 back stages.
// Throughput: one sample pair per cycle; the whole pipeline holds while a
// result is stalled at the output register.
// Reset: synchronous active-low rst_n clears all valid bits and zeroes the
// four coefficient registers.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_temp_compensation (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [19:0]                       in_adc_temperature,
  input  wire logic [19:0]                       in_adc_pressure,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [31:0]                     out_fine_temperature,
  output logic signed [23:0]                     out_temperature_centi,
  output logic [31:0]                            out_pressure_q24_8,
  output logic                                   out_divide_fault,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [btc_pkg::CfgIdxBits-1:0]    cfg_index,
  input  wire logic [63:0]                       cfg_data
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [47:0] temp_coef_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_nine_r;

  assign cfg_ready = 1'b1;

  // decode the register index of a write request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coef_r  <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_nine_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        btc_pkg::CFG_TEMP_COEF:  temp_coef_r  <= cfg_data[47:0];
        btc_pkg::CFG_PRESS_LOW:  press_low_r  <= cfg_data;
        btc_pkg::CFG_PRESS_HIGH: press_high_r <= cfg_data;
        btc_pkg::CFG_PRESS_NINE: press_nine_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coef_r[15:0];
  assign t2 = temp_coef_r[31:16];
  assign t3 = temp_coef_r[47:32];
  assign p1 = press_low_r[15:0];
  assign p2 = press_low_r[31:16];
  assign p3 = press_low_r[47:32];
  assign p4 = press_low_r[63:48];
  assign p5 = press_high_r[15:0];
  assign p6 = press_high_r[31:16];
  assign p7 = press_high_r[47:32];
  assign p8 = press_high_r[63:48];
  assign p9 = press_nine_r;

  // --------------------------------------------------------------------------
  // pipeline control: every stage advances unless the output is held
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic [10:1] vld_r;
  logic        div_vld;
  logic [3:1]  pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[9:1], in_valid};
      pv_r        <= {pv_r[2:1], div_vld};
      out_valid_r <= pv_r[3];
    end
  end

  // --------------------------------------------------------------------------
  // temperature path, 32-bit wrap
  // --------------------------------------------------------------------------
  logic [31:0] a1_r, b1_r;
  logic [19:0] adcp1_r, adcp2_r, adcp3_r, adcp4_r, adcp5_r, adcp6_r, adcp7_r, adcp8_r;
  logic [31:0] m1_r, bb2_r;
  logic [31:0] tv1_r, m2_r;
  logic [31:0] fine4_r;
  logic [31:0] a1_nxt, b1_nxt, fine4_nxt, tc5_nxt, bbs_nxt;

  always_comb begin
    a1_nxt    = {15'b0, in_adc_temperature[19:3]} - {15'b0, t1, 1'b0};
    b1_nxt    = {16'b0, in_adc_temperature[19:4]} - {16'b0, t1};
    bbs_nxt   = 32'($signed(bb2_r) >>> 12);
    fine4_nxt = tv1_r + 32'($signed(m2_r) >>> 14);
    tc5_nxt   = 32'($signed(fine4_r * 32'd5 + 32'(btc_pkg::RoundHalf)) >>> 8);
  end

  // stages one to four: differences, products, fine temperature
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= a1_nxt;
      b1_r    <= b1_nxt;
      adcp1_r <= in_adc_pressure;
      m1_r    <= a1_r * 32'(t2);
      bb2_r   <= b1_r * b1_r;
      adcp2_r <= adcp1_r;
      tv1_r   <= 32'($signed(m1_r) >>> 11);
      m2_r    <= bbs_nxt * 32'(t3);
      adcp3_r <= adcp2_r;
      fine4_r <= fine4_nxt;
      adcp4_r <= adcp3_r;
    end
  end

  // --------------------------------------------------------------------------
  // pressure path, 64-bit wrap
  // --------------------------------------------------------------------------
  btc_pkg::side_t     sd5_r, sd6_r, sd7_r, sd8_r, sd9_r, sd10_r;
  logic signed [32:0] v15_r;
  logic signed [63:0] vv6_r, v1p5_6_r, v1p2_6_r;
  logic signed [63:0] x6_7_r, x3_7_r, v1p5_7_r, v1p2_7_r;
  logic signed [63:0] v2_8_r, v1b_8_r;
  logic signed [63:0] m9_r, pn9_r;
  logic signed [63:0] d10_r, num10_r;
  logic signed [63:0] v2_nxt, v1b_nxt, pn_nxt;

  always_comb begin
    v2_nxt  = x6_7_r + (v1p5_7_r <<< 17) + (64'(p4) <<< 35);
    v1b_nxt = (x3_7_r >>> 8) + (v1p2_7_r <<< 12);
    pn_nxt  = $signed(((64'(btc_pkg::PressBase) - {44'b0, adcp8_r}) << 31) - v2_8_r);
  end

  // stages five to ten: build the dividend and the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r    <= '{fine: fine4_r, tcent: tc5_nxt[23:0], fault: 1'b0};
      v15_r    <= 33'($signed(fine4_r)) - 33'(btc_pkg::FineOffset);
      adcp5_r  <= adcp4_r;
      sd6_r    <= sd5_r;
      vv6_r    <= 64'(v15_r) * 64'(v15_r);
      v1p5_6_r <= 64'(v15_r) * 64'(p5);
      v1p2_6_r <= 64'(v15_r) * 64'(p2);
      adcp6_r  <= adcp5_r;
      sd7_r    <= sd6_r;
      x6_7_r   <= vv6_r * 64'(p6);
      x3_7_r   <= vv6_r * 64'(p3);
      v1p5_7_r <= v1p5_6_r;
      v1p2_7_r <= v1p2_6_r;
      adcp7_r  <= adcp6_r;
      sd8_r    <= sd7_r;
      v2_8_r   <= v2_nxt;
      v1b_8_r  <= v1b_nxt;
      adcp8_r  <= adcp7_r;
      sd9_r    <= sd8_r;
      m9_r     <= $signed((64'h0000_8000_0000_0000 + v1b_8_r) * {48'b0, p1});
      pn9_r    <= pn_nxt;
      sd10_r   <= sd9_r;
      d10_r    <= m9_r >>> 33;
      num10_r  <= $signed(pn9_r * 64'(btc_pkg::PressScale));
    end
  end

  // --------------------------------------------------------------------------
  // divider
  // --------------------------------------------------------------------------
  btc_pkg::side_t div_side_in, div_side;
  logic [63:0]    div_quo;

  assign div_side_in = '{fine: sd10_r.fine, tcent: sd10_r.tcent, fault: (d10_r == 64'sd0)};

  btc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[10]),
    .num      (num10_r),
    .den      (d10_r),
    .in_side  (div_side_in),
    .out_vld  (div_vld),
    .quo      (div_quo),
    .out_side (div_side)
  );

  // --------------------------------------------------------------------------
  // back stages: correction terms and output register
  // --------------------------------------------------------------------------
  btc_pkg::side_t     sdp1_r, sdp2_r, sdp3_r;
  logic signed [63:0] q1_r, w2m1_r;
  logic [63:0]        sql1_r;
  logic [31:0]        sqc1_r;
  logic signed [63:0] q2_r, w2m2_r, pp2_r;
  logic signed [63:0] q3_r, w2m3_r, w1m3_r;
  logic signed [63:0] ps_nxt, res_nxt;
  logic [31:0]        fine_o_r, press_o_r;
  logic [23:0]        tc_o_r;
  logic               fault_o_r;

  always_comb begin
    ps_nxt  = $signed(div_quo) >>> 13;
    res_nxt = ((q3_r + (w1m3_r >>> 25) + (w2m3_r >>> 19)) >>> 8) + (64'(p7) <<< 4);
  end

  // square of the scaled quotient from 32-bit halves, low 64 bits kept
  always_ff @(posedge clk) begin
    if (en) begin
      sdp1_r    <= div_side;
      q1_r      <= $signed(div_quo);
      sql1_r    <= 64'(ps_nxt[31:0]) * 64'(ps_nxt[31:0]);
      sqc1_r    <= ps_nxt[63:32] * ps_nxt[31:0];
      w2m1_r    <= 64'(p8) * $signed(div_quo);
      sdp2_r    <= sdp1_r;
      q2_r      <= q1_r;
      w2m2_r    <= w2m1_r;
      pp2_r     <= $signed(sql1_r + {sqc1_r[30:0], 33'b0});
      sdp3_r    <= sdp2_r;
      q3_r      <= q2_r;
      w2m3_r    <= w2m2_r;
      w1m3_r    <= 64'(p9) * pp2_r;
      fine_o_r  <= sdp3_r.fine;
      tc_o_r    <= sdp3_r.tcent;
      fault_o_r <= sdp3_r.fault;
      press_o_r <= sdp3_r.fault ? 32'd0 : res_nxt[31:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_fine_temperature  = fine_o_r;
  assign out_temperature_centi = tc_o_r;
  assign out_pressure_q24_8    = press_o_r;
  assign out_divide_fault      = fault_o_r;

endmodule

`default_nettype wire

// File: rtl/btc_div.sv
// ----------------------------------------------------------------------------
// btc_div - pipelined signed 64-bit divider
// One quotient bit per stage, truncating toward zero, one request per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic [btc_pkg::DivBits-1:0]   num,
  input  wire logic [btc_pkg::DivBits-1:0]   den,
  input  wire btc_pkg::side_t                in_side,
  output logic                               out_vld,
  output logic [btc_pkg::DivBits-1:0]        quo,
  output btc_pkg::side_t                     out_side
);

  localparam int unsigned W = btc_pkg::DivBits;

  logic [W:0]     rem_r  [0:W];
  logic [W-1:0]   quo_r  [0:W];
  logic [W-1:0]   den_r  [0:W];
  logic           neg_r  [0:W];
  btc_pkg::side_t side_r [0:W];
  logic           vld_r  [0:W];

  logic           out_vld_r;
  logic [W-1:0]   quo_out_r;
  btc_pkg::side_t side_out_r;

  logic [W-1:0] num_mag_nxt;
  logic [W-1:0] den_mag_nxt;

  // take magnitudes of both operands
  always_comb begin
    num_mag_nxt = num[W-1] ? (W'(0) - num) : num;
    den_mag_nxt = den[W-1] ? (W'(0) - den) : den;
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= num_mag_nxt;
      den_r[0]  <= den_mag_nxt;
      neg_r[0]  <= num[W-1] ^ den[W-1];
      side_r[0] <= in_side;
    end
  end

  // one restoring step per stage
  for (genvar g = 1; g <= W; g++) begin : g_step
    logic [W:0] shr_nxt;
    logic [W:0] dif_nxt;

    always_comb begin
      shr_nxt = {rem_r[g-1][W-1:0], quo_r[g-1][W-1]};
      dif_nxt = shr_nxt - {1'b0, den_r[g-1]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= dif_nxt[W] ? shr_nxt : dif_nxt;
        quo_r[g]  <= {quo_r[g-1][W-2:0], ~dif_nxt[W]};
        den_r[g]  <= den_r[g-1];
        neg_r[g]  <= neg_r[g-1];
        side_r[g] <= side_r[g-1];
      end
    end
  end

  // restore the sign of the quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_out_r  <= neg_r[W] ? (W'(0) - quo_r[W]) : quo_r[W];
      side_out_r <= side_r[W];
    end
  end

  assign out_vld  = out_vld_r;
  assign quo      = quo_out_r;
  assign out_side = side_out_r;

endmodule

`default_nettype wire

// File: rtl/btc_chk.sv
// ----------------------------------------------------------------------------
// btc_chk - port-level checks for the compensation block
// Watches the handshakes and the result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic signed [31:0]             out_fine_temperature,
  input wire logic signed [23:0]             out_temperature_centi,
  input wire logic [31:0]                    out_pressure_q24_8,
  input wire logic                           out_divide_fault
);

  logic [31:0] tc_chk;

  // recompute the centidegree value from the fine temperature
  assign tc_chk = 32'($signed(out_fine_temperature * 32'sd5 + 32'sd128) >>> 8);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // back-pressure only when a result waits at the output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a divide fault forces pressure to zero
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> out_pressure_q24_8 == 32'd0)
    else $error("pressure not zero on divide fault");

  // centidegree output matches the fine temperature of the same result
  a_tcent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature_centi == tc_chk[23:0])
    else $error("temperature mismatch with fine temperature");

endmodule

bind baro_temp_compensation btc_chk u_btc_chk (.*);

`default_nettype wire
